>>> rtl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// Types and constants shared by the telemetry frame parser modules.
// ----------------------------------------------------------------------------
package tfp_pkg;

	localparam int COUNT_W    = 6;
	localparam int FRAME_LEN  = 46;
	localparam int BODY_BASE  = 8;
	localparam int BODY_BYTES = 36;

	localparam logic [COUNT_W-1:0] FRAME_LEN_C = 6'd46;
	localparam logic [COUNT_W-1:0] CRC_SPAN    = 6'd44;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hffff;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hc5;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h5a;
	localparam logic [7:0] VERSION_RST     = 8'h01;

	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_VERSION     = 2'd2;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_LENGTH  = 3'd1,
		ST_BAD_SYNC    = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_BAD_CRC     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		FID_ATT_VALID = 4'd0,
		FID_GPS_VALID = 4'd1,
		FID_TIMESTAMP = 4'd2,
		FID_ROLL      = 4'd3,
		FID_PITCH     = 4'd4,
		FID_YAW       = 4'd5,
		FID_FIX       = 4'd6,
		FID_SATS      = 4'd7,
		FID_LAT       = 4'd8,
		FID_LON       = 4'd9,
		FID_ALT       = 4'd10,
		FID_REL_ALT   = 4'd11,
		FID_VX        = 4'd12,
		FID_VY        = 4'd13,
		FID_VZ        = 4'd14,
		FID_HEADING   = 4'd15
	} field_id_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_datagram;
	} rx_item_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  field_id;
		logic [63:0] field_value;
		logic        last_of_frame;
	} tx_item_t;

	typedef struct packed {
		logic [1:0] index;
		logic [7:0] data;
	} cfg_item_t;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] expected_version;
	} cfg_regs_t;

	typedef struct packed {
		status_t                   status;
		logic [7:0]                flags;
		logic [BODY_BYTES-1:0][7:0] body;
	} frame_t;

	function automatic logic [63:0] sext16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sext32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

endpackage

>>> rtl/tfp_stream_if.sv
// ----------------------------------------------------------------------------
// tfp_stream_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface tfp_stream_if #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/telemetry_frame_parser_crc16_unit.sv
// ----------------------------------------------------------------------------
// telemetry_frame_parser_crc16_unit
// Fixed-length telemetry frame parser with CRC-16/CCITT-FALSE check.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle on rx. Each byte passes an input register
// and is then folded into the byte count, the byte-wide CRC update and a
// 46-byte shift line. The length, sync, version and CRC checks run while the
// last byte sits in the input register, and the frame is then handed to a
// one-frame field buffer. Results leave tx from an output register at one
// per cycle while tx is ready: one status item for a bad frame or 16 field
// items for a good one. The first passes the field buffer and the output
// register on its way to tx. rx keeps taking a byte every cycle, including
// while results wait on tx; it holds off only while a datagram's last byte
// waits in the input register and the field buffer still has the previous
// frame's results to send. Configuration writes on cfg are taken at once.
// ----------------------------------------------------------------------------
module telemetry_frame_parser_crc16_unit (
	input  logic          clk,
	input  logic          arst_n,
	tfp_stream_if.sink    rx,
	tfp_stream_if.source  tx,
	tfp_stream_if.sink    cfg
);

	tfp_pkg::cfg_regs_t  cfg_q;
	tfp_pkg::frame_t     frame;
	logic                frame_load;
	logic                frame_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first       <= tfp_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second      <= tfp_pkg::SYNC_SECOND_RST;
			cfg_q.expected_version <= tfp_pkg::VERSION_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.payload.index)
				tfp_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first       <= cfg.payload.data;
				tfp_pkg::CFG_SYNC_SECOND: cfg_q.sync_second      <= cfg.payload.data;
				tfp_pkg::CFG_VERSION:     cfg_q.expected_version <= cfg.payload.data;
				default: begin
				end
			endcase
		end
	end

	tfp_framer u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.cfg_regs    (cfg_q),
		.frame_ready (frame_ready),
		.frame_load  (frame_load),
		.frame       (frame)
	);

	tfp_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_load  (frame_load),
		.frame       (frame),
		.frame_ready (frame_ready),
		.tx          (tx)
	);

endmodule

>>> rtl/tfp_crc.sv
// ----------------------------------------------------------------------------
// tfp_crc
// One byte of CRC-16/CCITT-FALSE, unrolled over the eight bits.
// ----------------------------------------------------------------------------
module tfp_crc (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data_byte,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data_byte, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ tfp_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

>>> rtl/tfp_framer.sv
// ----------------------------------------------------------------------------
// tfp_framer
// Input register, byte count, CRC and byte shift line; checks the frame at
// the datagram end and hands the result to the emitter.
// ----------------------------------------------------------------------------
module tfp_framer (
	input  logic                clk,
	input  logic                arst_n,
	tfp_stream_if.sink          rx,
	input  tfp_pkg::cfg_regs_t  cfg_regs,
	input  logic                frame_ready,
	output logic                frame_load,
	output tfp_pkg::frame_t     frame
);

	logic                                valid_s1;
	logic [7:0]                          byte_s1;
	logic                                last_s1;
	logic                                go;
	logic [tfp_pkg::COUNT_W-1:0]         count_q;
	logic [tfp_pkg::COUNT_W-1:0]         count_inc;
	logic [15:0]                         crc_q;
	logic [15:0]                         crc_step;
	logic [15:0]                         crc_d;
	logic [tfp_pkg::FRAME_LEN-1:0][7:0]  line_q;
	logic [tfp_pkg::FRAME_LEN-1:0][7:0]  line_d;
	logic [15:0]                         rx_crc;

	assign go       = valid_s1 && (!last_s1 || frame_ready);
	assign rx.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.payload.data_byte;
			last_s1 <= rx.payload.end_of_datagram;
		end
	end

	tfp_crc u_crc (
		.crc_in    (crc_q),
		.data_byte (byte_s1),
		.crc_out   (crc_step)
	);

	assign crc_d     = (count_q < tfp_pkg::CRC_SPAN) ? crc_step : crc_q;
	assign count_inc = (count_q == tfp_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
	// newest byte enters at the top; after a full frame byte k sits at index k
	assign line_d    = {byte_s1, line_q[tfp_pkg::FRAME_LEN-1:1]};
	assign rx_crc    = {line_d[45], line_d[44]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= tfp_pkg::CRC_INIT;
		end else if (go) begin
			if (last_s1) begin
				count_q <= '0;
				crc_q   <= tfp_pkg::CRC_INIT;
			end else begin
				count_q <= count_inc;
				crc_q   <= crc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			line_q <= line_d;
		end
	end

	assign frame_load = go && last_s1;

	always_comb begin
		priority if (count_inc != tfp_pkg::FRAME_LEN_C) begin
			frame.status = tfp_pkg::ST_BAD_LENGTH;
		end else if (line_d[0] != cfg_regs.sync_first
				|| line_d[1] != cfg_regs.sync_second) begin
			frame.status = tfp_pkg::ST_BAD_SYNC;
		end else if (line_d[2] != cfg_regs.expected_version) begin
			frame.status = tfp_pkg::ST_BAD_VERSION;
		end else if (rx_crc != crc_d) begin
			frame.status = tfp_pkg::ST_BAD_CRC;
		end else begin
			frame.status = tfp_pkg::ST_OK;
		end
		frame.flags = line_d[3];
		frame.body  = line_d[tfp_pkg::BODY_BASE+tfp_pkg::BODY_BYTES-1:tfp_pkg::BODY_BASE];
	end

endmodule

>>> rtl/tfp_emitter.sv
// ----------------------------------------------------------------------------
// tfp_emitter
// Holds one checked frame and steps through its fields into the output
// register, one result per cycle while the output register is free.
// ----------------------------------------------------------------------------
module tfp_emitter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_load,
	input  tfp_pkg::frame_t  frame,
	output logic             frame_ready,
	tfp_stream_if.source     tx
);

	logic               buf_valid_q;
	tfp_pkg::frame_t    frame_q;
	logic [3:0]         fid_q;
	logic               out_valid_q;
	tfp_pkg::tx_item_t  out_q;
	logic               out_free;
	logic               emit;
	logic               item_last;
	logic               frame_ok;
	logic [63:0]        value;
	tfp_pkg::tx_item_t  item;

	assign frame_ok    = (frame_q.status == tfp_pkg::ST_OK);
	assign item_last   = !frame_ok || (fid_q == tfp_pkg::FID_HEADING);
	assign out_free    = !out_valid_q || tx.ready;
	assign emit        = buf_valid_q && out_free;
	assign frame_ready = !buf_valid_q || (emit && item_last);

	always_comb begin
		unique case (tfp_pkg::field_id_t'(fid_q))
			tfp_pkg::FID_ATT_VALID: value = {63'd0, frame_q.flags[0]};
			tfp_pkg::FID_GPS_VALID: value = {63'd0, frame_q.flags[1]};
			tfp_pkg::FID_TIMESTAMP: value = frame_q.body[7:0];
			tfp_pkg::FID_ROLL:      value = tfp_pkg::sext16(frame_q.body[9:8]);
			tfp_pkg::FID_PITCH:     value = tfp_pkg::sext16(frame_q.body[11:10]);
			tfp_pkg::FID_YAW:       value = tfp_pkg::sext16(frame_q.body[13:12]);
			tfp_pkg::FID_FIX:       value = {56'd0, frame_q.body[14]};
			tfp_pkg::FID_SATS:      value = {56'd0, frame_q.body[15]};
			tfp_pkg::FID_LAT:       value = tfp_pkg::sext32(frame_q.body[19:16]);
			tfp_pkg::FID_LON:       value = tfp_pkg::sext32(frame_q.body[23:20]);
			tfp_pkg::FID_ALT:       value = tfp_pkg::sext16(frame_q.body[25:24]);
			tfp_pkg::FID_REL_ALT:   value = tfp_pkg::sext16(frame_q.body[27:26]);
			tfp_pkg::FID_VX:        value = tfp_pkg::sext16(frame_q.body[29:28]);
			tfp_pkg::FID_VY:        value = tfp_pkg::sext16(frame_q.body[31:30]);
			tfp_pkg::FID_VZ:        value = tfp_pkg::sext16(frame_q.body[33:32]);
			tfp_pkg::FID_HEADING:   value = {48'd0, frame_q.body[35:34]};
			default:                value = '0;
		endcase
	end

	always_comb begin
		item.status        = frame_q.status;
		item.field_id      = frame_ok ? fid_q : 4'd0;
		item.field_value   = frame_ok ? value : 64'd0;
		item.last_of_frame = item_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			fid_q       <= '0;
		end else if (frame_load) begin
			buf_valid_q <= 1'b1;
			fid_q       <= '0;
		end else if (emit && item_last) begin
			buf_valid_q <= 1'b0;
		end else if (emit) begin
			fid_q <= fid_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_load) begin
			frame_q <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= item;
		end
	end

	assign tx.valid   = out_valid_q;
	assign tx.payload = out_q;

`ifndef SYNTH
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != tfp_pkg::ST_OK
		|-> out_q.last_of_frame && out_q.field_value == 64'd0 && out_q.field_id == 4'd0)
		else $error("error result not a single zeroed item");

	a_good_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == tfp_pkg::ST_OK && out_q.last_of_frame
		|-> out_q.field_id == 4'(tfp_pkg::FID_HEADING))
		else $error("good frame ended before heading field");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		frame_load && buf_valid_q |-> emit && item_last)
		else $error("frame loaded over unfinished frame");

	a_fid_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !item_last && !frame_load |=> fid_q == $past(fid_q) + 4'd1)
		else $error("field sequencer skipped");
`endif

endmodule

>>> test/tfp_frame_checker.sv
// ----------------------------------------------------------------------------
// tfp_frame_checker
// Watches the rx, tx and cfg channels of the telemetry frame parser. It keeps
// its own copy of the byte count, running CRC-16/CCITT-FALSE, frame bytes and
// register values, predicts the status or field items of each datagram and
// compares every tx item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
package tfp_crc_pkg;

	import tfp_pkg::*;

	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		return c;
	endfunction

endpackage

module tfp_frame_checker
	import tfp_pkg::*;
	import tfp_crc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rx_valid,
	input  logic      rx_ready,
	input  rx_item_t  rx_item,
	input  logic      tx_valid,
	input  logic      tx_ready,
	input  tx_item_t  tx_item,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  cfg_item_t cfg_item,
	output int        mismatches,
	output int        outstanding
);

	logic [7:0]  sync_a;
	logic [7:0]  sync_b;
	logic [7:0]  version_want;
	logic [5:0]  seen;
	logic [15:0] crc_run;
	logic [7:0]  frame_bytes [FRAME_LEN];
	tx_item_t    results_due [$];
	tx_item_t    want;

	function automatic logic [63:0] le_word(input int pos, input int n);
		logic [63:0] v;
		v = '0;
		for (int i = n - 1; i >= 0; i--)
			v = {v[55:0], frame_bytes[pos + i]};
		return v;
	endfunction

	function automatic logic [63:0] widen16(input logic [63:0] v);
		return {{48{v[15]}}, v[15:0]};
	endfunction

	function automatic logic [63:0] widen32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [63:0] field_word(input field_id_t id);
		case (id)
		FID_ATT_VALID: return {63'd0, frame_bytes[3][0]};
		FID_GPS_VALID: return {63'd0, frame_bytes[3][1]};
		FID_TIMESTAMP: return le_word(8, 8);
		FID_ROLL:      return widen16(le_word(16, 2));
		FID_PITCH:     return widen16(le_word(18, 2));
		FID_YAW:       return widen16(le_word(20, 2));
		FID_FIX:       return {56'd0, frame_bytes[22]};
		FID_SATS:      return {56'd0, frame_bytes[23]};
		FID_LAT:       return widen32(le_word(24, 4));
		FID_LON:       return widen32(le_word(28, 4));
		FID_ALT:       return widen16(le_word(32, 2));
		FID_REL_ALT:   return widen16(le_word(34, 2));
		FID_VX:        return widen16(le_word(36, 2));
		FID_VY:        return widen16(le_word(38, 2));
		FID_VZ:        return widen16(le_word(40, 2));
		default:       return le_word(42, 2);
		endcase
	endfunction

	task automatic parse_byte(input rx_item_t it);
		status_t  verdict;
		tx_item_t res;
		if (seen < FRAME_LEN_C)
			frame_bytes[seen] = it.data_byte;
		if (seen < CRC_SPAN)
			crc_run = crc16_fold(crc_run, it.data_byte);
		if (seen != COUNT_MAX)
			seen = seen + 1'b1;
		if (!it.end_of_datagram)
			return;
		if (seen != FRAME_LEN_C)
			verdict = ST_BAD_LENGTH;
		else if (frame_bytes[0] != sync_a || frame_bytes[1] != sync_b)
			verdict = ST_BAD_SYNC;
		else if (frame_bytes[2] != version_want)
			verdict = ST_BAD_VERSION;
		else if ({frame_bytes[45], frame_bytes[44]} != crc_run)
			verdict = ST_BAD_CRC;
		else
			verdict = ST_OK;
		seen = '0;
		crc_run = CRC_INIT;
		if (verdict != ST_OK) begin
			res.status = verdict;
			res.field_id = '0;
			res.field_value = '0;
			res.last_of_frame = 1'b1;
			results_due.push_back(res);
		end else begin
			for (int k = 0; k < 16; k++) begin
				res.status = ST_OK;
				res.field_id = k[3:0];
				res.field_value = field_word(field_id_t'(k));
				res.last_of_frame = (k == 15);
				results_due.push_back(res);
			end
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] exp_v, input logic [63:0] got);
		if (got !== exp_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, exp_v, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_a = SYNC_FIRST_RST;
			sync_b = SYNC_SECOND_RST;
			version_want = VERSION_RST;
			seen = '0;
			crc_run = CRC_INIT;
			results_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (tx_valid && tx_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: item expected none actual %0h", $time, tx_item);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("status", 64'(want.status), 64'(tx_item.status));
					check_field("field_id", 64'(want.field_id), 64'(tx_item.field_id));
					check_field("field_value", want.field_value, tx_item.field_value);
					check_field("last_of_frame", 64'(want.last_of_frame),
						64'(tx_item.last_of_frame));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_item.index)
				CFG_SYNC_FIRST:  sync_a = cfg_item.data;
				CFG_SYNC_SECOND: sync_b = cfg_item.data;
				CFG_VERSION:     version_want = cfg_item.data;
				default: ;
				endcase
			end
			if (rx_valid && rx_ready)
				parse_byte(rx_item);
			outstanding = results_due.size();
		end
	end

endmodule

>>> test/telemetry_frame_parser_crc16_unit_tb.sv
// ----------------------------------------------------------------------------
// telemetry_frame_parser_crc16_unit_tb
// Feeds the parser with short directed datagrams and a long one, then random
// datagrams, about half well-formed frames with mostly random content, the
// rest bad sync, bad version, bad CRC, short, long and noise datagrams,
// under several register settings. Both channel ends idle in random bursts;
// the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module telemetry_frame_parser_crc16_unit_tb;

	import tfp_pkg::*;
	import tfp_crc_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 16;
	localparam int PHASE_BYTES = 24;
	localparam int DG_MAX      = 80;

	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef enum int {
		DG_GOOD,
		DG_BAD_SYNC,
		DG_BAD_VERSION,
		DG_BAD_CRC,
		DG_SHORT,
		DG_LONG,
		DG_NOISE
	} dg_kind_t;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	logic       clk;
	logic       arst_n;
	logic       calm;
	logic       gappy;
	logic [7:0] want_sync_a;
	logic [7:0] want_sync_b;
	logic [7:0] want_version;
	int         bytes_sent;
	int         cycle_count = 0;
	int         mismatches;
	int         outstanding;

	tfp_stream_if #(.item_t(rx_item_t))  rx_if ();
	tfp_stream_if #(.item_t(tx_item_t))  tx_if ();
	tfp_stream_if #(.item_t(cfg_item_t)) cfg_if ();

	telemetry_frame_parser_crc16_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if),
		.cfg    (cfg_if)
	);

	tfp_frame_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_if.valid),
		.rx_ready    (rx_if.ready),
		.rx_item     (rx_if.payload),
		.tx_valid    (tx_if.valid),
		.tx_ready    (tx_if.ready),
		.tx_item     (tx_if.payload),
		.cfg_valid   (cfg_if.valid),
		.cfg_ready   (cfg_if.ready),
		.cfg_item    (cfg_if.payload),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side back-pressure in random bursts
	initial begin
		int stall;
		stall = 0;
		tx_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall != 0) begin
				stall--;
			end else if (!calm && gappy && $urandom_range(0, 4) == 0) begin
				tx_if.ready <= 1'b0;
				stall = $urandom_range(0, 3);
			end else begin
				tx_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!calm && gappy && $urandom_range(0, 5) == 0) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.payload <= {b, last};
		do @(posedge clk); while (!rx_if.ready);
		bytes_sent++;
	endtask

	task automatic write_regs(input logic [7:0] a, input logic [7:0] b, input logic [7:0] v,
			input logic spare);
		cfg_item_t writes [$];
		cfg_item_t w;
		w.index = CFG_SYNC_FIRST;
		w.data = a;
		writes.push_back(w);
		if (spare) begin
			w.index = CFG_SPARE;
			w.data = 8'($urandom);
			writes.push_back(w);
		end
		w.index = CFG_SYNC_SECOND;
		w.data = b;
		writes.push_back(w);
		w.index = CFG_VERSION;
		w.data = v;
		writes.push_back(w);
		foreach (writes[i]) begin
			cfg_if.valid <= 1'b1;
			cfg_if.payload <= writes[i];
			do @(posedge clk); while (!cfg_if.ready);
		end
		cfg_if.valid <= 1'b0;
		want_sync_a = a;
		want_sync_b = b;
		want_version = v;
	endtask

	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic dg_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 11);
		case (r)
		6:       return DG_BAD_SYNC;
		7:       return DG_BAD_VERSION;
		8:       return DG_BAD_CRC;
		9:       return DG_SHORT;
		10:      return DG_LONG;
		11:      return DG_NOISE;
		default: return DG_GOOD;
		endcase
	endfunction

	task automatic send_datagram(input dg_kind_t kind, input fill_t fill);
		logic [7:0]  dg [DG_MAX];
		logic [15:0] crc;
		logic [7:0]  m0;
		logic [7:0]  m1;
		logic [7:0]  m2;
		logic        late;
		int          len;
		for (int i = 0; i < DG_MAX; i++)
			dg[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hff : 8'($urandom);
		dg[0] = want_sync_a;
		dg[1] = want_sync_b;
		dg[2] = want_version;
		m0 = '0;
		m1 = '0;
		m2 = '0;
		case (kind)
		DG_BAD_SYNC: begin
			if ($urandom_range(0, 1))
				m0 = 8'($urandom_range(1, 255));
			else
				m1 = 8'($urandom_range(1, 255));
			if ($urandom_range(0, 1))
				m2 = 8'($urandom_range(1, 255));
		end
		DG_BAD_VERSION: m2 = 8'($urandom_range(1, 255));
		default: ;
		endcase
		// a header fault made after the crc is worked out also spoils the crc
		late = $urandom_range(0, 1);
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == int'(late)) begin
				dg[0] ^= m0;
				dg[1] ^= m1;
				dg[2] ^= m2;
			end
			if (pass == 0) begin
				crc = CRC_INIT;
				for (int i = 0; i < 44; i++)
					crc = crc16_fold(crc, dg[i]);
				dg[44] = crc[7:0];
				dg[45] = crc[15:8];
			end
		end
		if (kind == DG_BAD_CRC)
			dg[$urandom_range(3, 45)] ^= 8'($urandom_range(1, 255));
		case (kind)
		DG_SHORT: len = $urandom_range(1, 45);
		DG_LONG:  len = $urandom_range(47, DG_MAX);
		DG_NOISE: begin
			len = $urandom_range(1, 60);
			for (int i = 0; i < len; i++)
				dg[i] = 8'($urandom);
		end
		default:  len = 46;
		endcase
		for (int i = 0; i < len; i++)
			send_byte(dg[i], i == len - 1);
	endtask

	initial begin
		int    k;
		int    r;
		fill_t fill;
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.payload <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.payload <= '0;
		calm <= 1'b0;
		gappy <= 1'b1;
		want_sync_a = SYNC_FIRST_RST;
		want_sync_b = SYNC_SECOND_RST;
		want_version = VERSION_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			1: write_regs(8'h00, 8'h00, 8'h00, 1'b0);
			2: write_regs(8'hff, 8'hff, 8'hff, 1'b1);
			3: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
			4: begin
				calm <= 1'b1;
				write_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, VERSION_RST, 1'b1);
			end
			default: ;
			endcase
			if (ph == 0) begin
				// one-byte datagrams and a two-byte one holding only the sync
				send_byte(8'h00, 1'b1);
				send_byte(8'hff, 1'b1);
				send_byte(SYNC_FIRST_RST, 1'b0);
				send_byte(SYNC_SECOND_RST, 1'b1);
				send_datagram(DG_LONG, FILL_RANDOM);
			end
			bytes_sent = 0;
			k = 0;
			while (bytes_sent < PHASE_BYTES) begin
				gappy <= ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 9);
				fill = (r == 0) ? FILL_ONES : (r == 1) ? FILL_ZERO : FILL_RANDOM;
				if (k == 0 && ph < 2)
					send_datagram(DG_GOOD, (ph == 0) ? FILL_ONES : FILL_ZERO);
				else
					send_datagram(pick_kind(), fill);
				k++;
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
